@@ hw/rtl/lfid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfid_pkg
// Shared constants, request codes and controller/datapath interface types
// for the lowest-free ID allocator.
// ----------------------------------------------------------------------------
package lfid_pkg;

  localparam int ID_COUNT_DEF = 1024;   // default pool size
  localparam int WORD_W       = 32;     // bitmap word width
  localparam int WBITS        = 5;      // log2(WORD_W)
  localparam int FUNC_W       = 3;
  localparam int ID_W         = 10;
  localparam int END_W        = 11;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 16;

  // request codes carried on in_tuser
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RANGE   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_AFR     = 3'd4;

  // internal word operation
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_FIND  = 2'd1,
    OP_CLAIM = 2'd2,
    OP_FREE  = 2'd3
  } lfid_op_t;

  typedef struct packed {
    logic clr_en;     // write one init word of the clearing pass
    logic accept;     // load a new request
    logic rd_en;      // read the current bitmap word
    logic ex_en;      // modify and write back the current word
    logic load_out;   // move result into the output register
  } lfid_cmd_t;

  typedef struct packed {
    logic clr_last;   // clearing pass on its last word
    logic idle_done;  // request needs no bitmap access
    logic ex_done;    // word step finishes the request
  } lfid_sts_t;

  // index of the single set bit of a one-hot word
  function automatic logic [WBITS-1:0] lowbit_index(input logic [WORD_W-1:0] onehot);
    logic [WBITS-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (onehot[i]) begin
        idx = idx | WBITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/lfid_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfid_ctrl
// Sequencer for the allocator: clearing pass, request intake, word-by-word
// read-modify-write scan and result hand-off.
// ----------------------------------------------------------------------------
module lfid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                out_tready,
  output logic                out_tvalid,
  output lfid_pkg::lfid_cmd_t cmd,
  input  lfid_pkg::lfid_sts_t sts
);
  import lfid_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_START = 6'b000100,
    S_RD    = 6'b001000,
    S_EX    = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        state_nxt = sts.idle_done ? S_FIN : S_RD;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        cmd.ex_en = 1'b1;
        state_nxt = sts.ex_done ? S_FIN : S_RD;
      end
      S_FIN: begin
        // hold the finished result until the output register is free
        if (!out_tvalid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while a request is in flight");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_tvalid_r && !out_tready) |=> (state_r == S_FIN && out_tvalid))
    else $error("finished result dropped while output stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("loaded result not presented");

  a_scan_loops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EX && !sts.ex_done) |=> (state_r == S_RD))
    else $error("unfinished scan did not fetch the next word");
`endif

endmodule

@@ hw/rtl/lfid_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfid_dp
// Datapath: free bitmap memory (one bit per ID, 32-bit words), scan
// position and limit, per-word find/claim/free logic and result registers.
// ----------------------------------------------------------------------------
module lfid_dp #(
  parameter int ID_COUNT = lfid_pkg::ID_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lfid_pkg::lfid_cmd_t           cmd,
  output lfid_pkg::lfid_sts_t           sts,
  input  logic [lfid_pkg::FUNC_W-1:0]   in_func,
  input  logic [lfid_pkg::ID_W-1:0]     in_id,
  input  logic [lfid_pkg::END_W-1:0]    in_end,
  output logic [lfid_pkg::ID_W-1:0]     id_out,
  output logic                          ok_out
);
  import lfid_pkg::*;

  localparam int IDB    = $clog2(ID_COUNT);
  localparam int CW     = (IDB + 1 > END_W) ? IDB + 1 : END_W;
  localparam int NWORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int TAIL   = ID_COUNT % WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK =
    (TAIL == 0) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << TAIL) - 64'd1);
  localparam logic [CW-1:0] COUNT_C   = CW'(ID_COUNT);
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

  logic [WORD_W-1:0] mem [NWORDS];
  logic [WORD_W-1:0] rd_data_r;

  logic [AW-1:0]   clr_r, clr_nxt;
  lfid_op_t        op_r, op_nxt;
  logic [CW-1:0]   cur_r, cur_nxt;
  logic [CW-1:0]   lim_r, lim_nxt;
  logic            act_r, act_nxt;
  logic            ret_r, ret_nxt;
  logic [ID_W-1:0] res_id_r, res_id_nxt;
  logic            res_ok_r, res_ok_nxt;
  logic [ID_W-1:0] out_id_r;
  logic            out_ok_r;

  logic [CW-1:0]     id_x, end_x, idp1, end_min;
  logic [CW-1:0]     word_base, next_cur, find_id;
  logic [AW-1:0]     addr;
  logic [WBITS-1:0]  lo;
  logic [WORD_W-1:0] hi_mask, rng_mask, cand, cand_low, bad, bad_low;
  logic [WORD_W-1:0] wr_data, init_word;
  logic              wr_en, ex_done;

  // ---- request decode ----
  assign id_x    = CW'(in_id);
  assign end_x   = CW'(in_end);
  assign idp1    = id_x + CW'(1);
  assign end_min = (end_x > COUNT_C) ? COUNT_C : end_x;

  // ---- word step ----
  assign word_base = {cur_r[CW-1:WBITS], {WBITS{1'b0}}};
  assign next_cur  = word_base + CW'(WORD_W);
  assign addr      = cur_r[AW+WBITS-1:WBITS];
  assign lo        = cur_r[WBITS-1:0];
  assign hi_mask   = (lim_r[CW-1:WBITS] == cur_r[CW-1:WBITS]) ?
                     ((WORD_W'(1) << lim_r[WBITS-1:0]) - WORD_W'(1)) : {WORD_W{1'b1}};
  assign rng_mask  = ({WORD_W{1'b1}} << lo) & hi_mask;
  assign cand      = rd_data_r & rng_mask;
  assign cand_low  = cand & (~cand + WORD_W'(1));
  assign bad       = ~rd_data_r & rng_mask;
  assign bad_low   = bad & (~bad + WORD_W'(1));
  assign find_id   = word_base | CW'(lowbit_index(cand_low));

  always_comb begin
    op_nxt     = op_r;
    cur_nxt    = cur_r;
    lim_nxt    = lim_r;
    act_nxt    = act_r;
    ret_nxt    = ret_r;
    res_id_nxt = res_id_r;
    res_ok_nxt = res_ok_r;
    wr_en      = 1'b0;
    wr_data    = rd_data_r;
    ex_done    = 1'b0;

    case (op_r)
      OP_FIND: begin
        if (|cand) begin
          wr_en      = 1'b1;
          wr_data    = rd_data_r & ~cand_low;
          ex_done    = 1'b1;
          res_id_nxt = find_id[ID_W-1:0];
          res_ok_nxt = 1'b1;
        end else begin
          cur_nxt = next_cur;
          ex_done = (next_cur >= lim_r);
        end
      end
      OP_CLAIM: begin
        wr_en = 1'b1;
        if (bad == '0) begin
          wr_data = rd_data_r & ~rng_mask;
          cur_nxt = next_cur;
          ex_done = (next_cur >= lim_r);
          if (ret_r) begin
            res_id_nxt = cur_r[ID_W-1:0];   // single-ID claim returns the ID
          end
        end else begin
          // keep the claims below the first used ID
          wr_data    = rd_data_r & ~(rng_mask & (bad_low - WORD_W'(1)));
          ex_done    = 1'b1;
          res_ok_nxt = 1'b0;
        end
      end
      OP_FREE: begin
        wr_en      = 1'b1;
        wr_data    = rd_data_r | (WORD_W'(1) << lo);
        ex_done    = 1'b1;
        res_ok_nxt = 1'b1;
      end
      default: begin
        ex_done = 1'b1;
      end
    endcase

    if (!cmd.ex_en) begin
      op_nxt     = op_r;
      cur_nxt    = cur_r;
      res_id_nxt = res_id_r;
      res_ok_nxt = res_ok_r;
      wr_en      = 1'b0;
    end

    if (cmd.accept) begin
      cur_nxt    = id_x;
      lim_nxt    = COUNT_C;
      act_nxt    = 1'b1;
      ret_nxt    = 1'b0;
      res_id_nxt = '0;
      res_ok_nxt = 1'b0;
      case (in_func)
        FUNC_ALLOC: begin
          op_nxt  = OP_FIND;
          cur_nxt = CW'(1);
        end
        FUNC_RELEASE: begin
          op_nxt  = OP_FREE;
          act_nxt = (id_x != '0) && (id_x < COUNT_C);
        end
        FUNC_MARK: begin
          op_nxt     = OP_CLAIM;
          lim_nxt    = (idp1 > COUNT_C) ? COUNT_C : idp1;
          res_ok_nxt = !(idp1 > COUNT_C);
          ret_nxt    = 1'b1;
        end
        FUNC_RANGE: begin
          op_nxt     = OP_CLAIM;
          lim_nxt    = end_min;
          // IDs past the pool count as used, so such a range cannot succeed
          res_ok_nxt = !((end_x > COUNT_C) && (id_x < end_x));
        end
        FUNC_AFR: begin
          op_nxt  = OP_FIND;
          lim_nxt = end_min;
        end
        default: begin
          op_nxt = OP_NONE;
        end
      endcase
    end
  end

  // ---- clearing pass ----
  always_comb begin
    init_word = (clr_r == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}};
    if (clr_r == '0) begin
      init_word[0] = 1'b0;   // ID zero is never free
    end
  end

  assign clr_nxt = cmd.clr_en ? clr_r + AW'(1) : clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  // ---- bitmap memory ----
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_r] <= init_word;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // ---- request and result registers ----
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    cur_r    <= cur_nxt;
    lim_r    <= lim_nxt;
    act_r    <= act_nxt;
    ret_r    <= ret_nxt;
    res_id_r <= res_id_nxt;
    res_ok_r <= res_ok_nxt;
    if (cmd.load_out) begin
      out_id_r <= res_id_r;
      out_ok_r <= res_ok_r;
    end
  end

  assign sts.clr_last  = (clr_r == LAST_WORD);
  assign sts.idle_done = (op_r == OP_NONE) ||
                         ((op_r == OP_FREE) ? !act_r : (cur_r >= lim_r));
  assign sts.ex_done   = ex_done;

  assign id_out = out_id_r;
  assign ok_out = out_ok_r;

`ifndef SYNTH
  a_addr_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ex_en |-> (cur_r < COUNT_C))
    else $error("bitmap access beyond the pool");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ex_en && (op_r == OP_FIND || op_r == OP_CLAIM)) |-> (cur_r < lim_r))
    else $error("scan step outside the requested range");

  a_find_claims_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ex_en && op_r == OP_FIND && (|cand)) |=> (res_ok_r && res_id_r != '0))
    else $error("found ID not reported");
`endif

endmodule

@@ hw/rtl/lowest_free_id_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Lowest-free ID allocator over a bitmap with allocate, release, mark-used,
// mark-range and allocate-from-range requests.
// ----------------------------------------------------------------------------
// One request is handled at a time; the result waits in an output register
// while the next request is taken. The bitmap is a single-port memory of
// 32-bit words, and every word a request touches is read, then modified and
// written back. Release and mark-used touch one word, allocate and the range
// requests one per word scanned, and some requests need no bitmap access.
// After reset a clearing pass writes ceil(ID_COUNT/32) words before the
// first request is accepted.
module lowest_free_id_allocator #(
  parameter int ID_COUNT = lfid_pkg::ID_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lfid_pkg::IN_DATA_W-1:0]    in_tdata,   // id_value[9:0], range_end[20:10]
  input  logic [lfid_pkg::FUNC_W-1:0]       in_tuser,   // func[2:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lfid_pkg::OUT_DATA_W-1:0]   out_tdata,  // id_out[9:0]
  output logic                              out_tuser   // ok
);
  import lfid_pkg::*;

  lfid_cmd_t       cmd;
  lfid_sts_t       sts;
  logic [ID_W-1:0] id_out;

  lfid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  lfid_dp #(
    .ID_COUNT (ID_COUNT)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_func (in_tuser),
    .in_id   (in_tdata[ID_W-1:0]),
    .in_end  (in_tdata[ID_W+END_W-1:ID_W]),
    .id_out  (id_out),
    .ok_out  (out_tuser)
  );

  assign out_tdata = {{(OUT_DATA_W-ID_W){1'b0}}, id_out};

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lowest-free ID allocator. A bitmap predictor
// tracks which IDs are free and computes the grant that each accepted request
// must return. Directed tests cover every request type and the corner cases.
// Random traffic follows: release-heavy, then allocate-heavy. Both stream
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import lfid_pkg::*;

  localparam int POOL_SIZE      = ID_COUNT_DEF;
  localparam int DRAIN_CYCLES   = 80;     // longer than a full bitmap scan
  localparam int WATCHDOG_LIMIT = 3000;

  // codes the block must treat as no-ops
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            ok;
  } grant_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  bit     id_free [POOL_SIZE];
  grant_t pending_grants [$];
  grant_t want;
  int     mismatches  = 0;
  int     requests    = 0;
  int     directed    = 0;
  int     checked     = 0;
  int     empty_hits  = 0;
  int     idle_cycles = 0;
  bit     no_idle     = 1'b0;

  lowest_free_id_allocator #(
    .ID_COUNT(POOL_SIZE)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit claim_id(input int i);
    if (i < POOL_SIZE && id_free[i]) begin
      id_free[i] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic grant_t compute_grant(input logic [FUNC_W-1:0] f,
                                           input logic [ID_W-1:0] id,
                                           input logic [END_W-1:0] e);
    grant_t g;
    int     i;
    g.id = '0;
    g.ok = 1'b0;
    case (f)
      FUNC_ALLOC: begin
        for (i = 1; i < POOL_SIZE && !g.ok; i++) begin
          if (claim_id(i)) begin
            g.id = ID_W'(i);
            g.ok = 1'b1;
          end
        end
      end
      FUNC_RELEASE: begin
        if (id != 0 && int'(id) < POOL_SIZE) begin
          id_free[id] = 1'b1;
          g.ok = 1'b1;
        end
      end
      FUNC_MARK: begin
        if (claim_id(int'(id))) begin
          g.id = id;
          g.ok = 1'b1;
        end
      end
      FUNC_RANGE: begin
        // earlier claims stick when the run hits a used ID
        g.ok = 1'b1;
        for (i = int'(id); i < int'(e) && g.ok; i++) begin
          if (!claim_id(i)) g.ok = 1'b0;
        end
      end
      FUNC_AFR: begin
        for (i = int'(id); i < int'(e) && !g.ok; i++) begin
          if (claim_id(i)) begin
            g.id = ID_W'(i);
            g.ok = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // called and returns at a falling edge; tvalid stays high after the
  // transaction so back-to-back requests need no second assignment
  task automatic issue_request(input logic [FUNC_W-1:0] f, input int id, input int e);
    int     gap;
    grant_t g;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= f;
    in_tdata  <= {3'b000, END_W'(e), ID_W'(id)};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    g = compute_grant(f, ID_W'(id), END_W'(e));
    if (f == FUNC_ALLOC && !g.ok) empty_hits++;
    pending_grants.push_back(g);
    requests++;
    @(negedge clk);
  endtask

  task automatic wait_all_granted();
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_alloc_release();
    issue_request(FUNC_ALLOC, 0, 0);
    issue_request(FUNC_ALLOC, 0, 0);
    issue_request(FUNC_RELEASE, 1, 0);
    issue_request(FUNC_RELEASE, 1, 0);      // already free: still ok
    issue_request(FUNC_RELEASE, 0, 0);      // ID zero is never released
    issue_request(FUNC_RELEASE, 2, 0);
  endtask

  task automatic test_mark_used();
    issue_request(FUNC_MARK, POOL_SIZE - 1, 0);
    issue_request(FUNC_MARK, POOL_SIZE - 1, 0);
    issue_request(FUNC_MARK, 0, 0);
  endtask

  task automatic test_mark_range();
    issue_request(FUNC_RANGE, 10, 20);
    issue_request(FUNC_RANGE, 5, 12);       // stops at 10, keeps 5..9
    issue_request(FUNC_RANGE, 50, 50);      // empty
    issue_request(FUNC_RANGE, 700, 3);      // end below start
  endtask

  task automatic test_alloc_from_range();
    issue_request(FUNC_AFR, 5, 12);         // nothing free in there
    issue_request(FUNC_AFR, 30, 30);
    issue_request(FUNC_AFR, 1000, POOL_SIZE);
  endtask

  task automatic test_unused_codes();
    issue_request(FUNC_UNUSED_LO, 3, 40);
    issue_request(FUNC_UNUSED_HI, POOL_SIZE - 1, POOL_SIZE);
  endtask

  task automatic test_pool_exhaustion();
    int lo;
    int hi;
    // claim each remaining free run with one range request
    for (lo = 1; lo < POOL_SIZE; lo++) begin
      if (id_free[lo]) begin
        hi = lo;
        while (hi < POOL_SIZE && id_free[hi]) hi++;
        issue_request(FUNC_RANGE, lo, hi);
        lo = hi;
      end
    end
    issue_request(FUNC_ALLOC, 0, 0);
    issue_request(FUNC_RELEASE, POOL_SIZE - 1, 0);
    issue_request(FUNC_ALLOC, 0, 0);
    issue_request(FUNC_AFR, 1, POOL_SIZE);
  endtask

  task automatic test_random(input int count, input int release_pct);
    int                r;
    int                n;
    int                k;
    int                id;
    int                e;
    logic [FUNC_W-1:0] f;
    for (n = 0; n < count; n++) begin
      r  = $urandom_range(0, 99);
      id = $urandom_range(0, POOL_SIZE - 1);
      e  = 0;
      if (r < release_pct) begin
        f = FUNC_RELEASE;
        // mostly target IDs that are in use
        if ($urandom_range(0, 9) != 0) begin
          for (k = 0; k < 16 && id_free[id]; k++) id = $urandom_range(1, POOL_SIZE - 1);
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          f = FUNC_ALLOC;
        end else if (r < 65) begin
          f = FUNC_MARK;
        end else if (r < 80) begin
          f = FUNC_RANGE;
          k = $urandom_range(0, 9);
          if (k < 8) e = id + $urandom_range(0, 24);
          else if (k == 8) e = $urandom_range(0, POOL_SIZE);
          else e = POOL_SIZE;
        end else if (r < 96) begin
          f = FUNC_AFR;
          if ($urandom_range(0, 9) < 3) id = 1;
          k = $urandom_range(0, 19);
          if (k < 14) e = id + $urandom_range(0, 300);
          else if (k < 17) e = POOL_SIZE;
          else e = $urandom_range(0, POOL_SIZE);
        end else begin
          f = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
          e = $urandom_range(0, POOL_SIZE);
        end
        if (e > POOL_SIZE) e = POOL_SIZE;
      end
      issue_request(f, id, e);
    end
  endtask

  // ---------------------------------------------------------------- result side
  initial begin : result_sink
    int n;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n != 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      checked++;
      if (pending_grants.size() == 0) begin
        $error("unexpected result: id_out %0d ok %0b", out_tdata[ID_W-1:0], out_tuser);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        if (out_tdata[ID_W-1:0] !== want.id) begin
          $error("id_out: expected %0d, actual %0d", want.id, out_tdata[ID_W-1:0]);
          mismatches++;
        end
        if (out_tuser !== want.ok) begin
          $error("ok: expected %0b, actual %0b", want.ok, out_tuser);
          mismatches++;
        end
        if (out_tdata[OUT_DATA_W-1:ID_W] !== '0) begin
          $error("tdata pad: expected 0, actual %0h", out_tdata[OUT_DATA_W-1:ID_W]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_ALLOC;
    foreach (id_free[i]) id_free[i] = (i != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_alloc_release();
    test_mark_used();
    test_mark_range();
    test_alloc_from_range();
    test_unused_codes();
    test_pool_exhaustion();
    directed = requests;

    test_random(540, 45);
    wait_all_granted();
    no_idle = 1'b1;
    test_random(150, 15);
    no_idle = 1'b0;
    test_random(400, 15);

    wait_all_granted();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d requests (%0d directed), %0d results checked", requests, directed,
             checked);
    $display("summary: %0d allocations found the pool empty", empty_hits);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
